### rtl/tmmb_pkg.sv
// ============================================================================
// TRS model matrix builder package
// Shared widths, payload types, constants, latency helpers and a rounding helper.
// ============================================================================
`default_nettype none

package tmmb_pkg;

    localparam int WORD_WIDTH = 32;
    localparam int Q_W        = 34;
    localparam int Q_FRAC     = 30;
    localparam int ATAN_LEN   = 24;
    localparam int DEG_HALF   = 180;
    localparam int DEG_FULL   = 360;
    localparam int RES_W      = 9;
    localparam int PI_W       = 26;

    localparam int MOD_STEPS_PER_STAGE    = 2;
    localparam int CORDIC_STEPS_PER_STAGE = 2;

    localparam logic [31:0]     GAIN_INV_Q30    = 32'd652032874;
    localparam logic [PI_W-1:0] PI_OVER_360_Q32 = 26'd37480660;

    localparam logic [31:0] ATAN_Q30 [ATAN_LEN] = '{
        32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
        32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
        32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
        32'd262144,    32'd131072,    32'd65536,     32'd32768,
        32'd16384,     32'd8192,      32'd4096,      32'd2048,
        32'd1024,      32'd512,       32'd256,       32'd128
    };

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic signed [Q_W-1:0]        q_t;
    typedef logic signed [2*Q_W-1:0]      prod_t;
    typedef logic signed [2*Q_W+1:0]      acc_t;

    localparam q_t Q_ONE = q_t'(1) <<< Q_FRAC;

    typedef struct packed {
        word_t pos_x;
        word_t pos_y;
        word_t pos_z;
        word_t angle_x;
        word_t angle_y;
        word_t angle_z;
        word_t scale_x;
        word_t scale_y;
        word_t scale_z;
    } trs_in_t;

    typedef struct packed {
        word_t m00;
        word_t m01;
        word_t m02;
        word_t m03;
        word_t m10;
        word_t m11;
        word_t m12;
        word_t m13;
        word_t m20;
        word_t m21;
        word_t m22;
        word_t m23;
    } trs_out_t;

    function automatic int cordic_steps(input int trig_steps);
        return (trig_steps > ATAN_LEN) ? ATAN_LEN : trig_steps;
    endfunction

    function automatic int lane_latency(input int frac_bits, input int trig_steps);
        int mod_stages;
        int rot_stages;
        mod_stages = (WORD_WIDTH - frac_bits + MOD_STEPS_PER_STAGE - 1) / MOD_STEPS_PER_STAGE;
        rot_stages = (cordic_steps(trig_steps) + CORDIC_STEPS_PER_STAGE - 1)
                     / CORDIC_STEPS_PER_STAGE;
        return mod_stages + rot_stages + 5;
    endfunction

    // Round a Q60 value to Q30, half up, floor on the shift.
    function automatic q_t rnd30(input acc_t p);
        acc_t rounded;
        rounded = (p + (acc_t'(1) <<< (Q_FRAC - 1))) >>> Q_FRAC;
        return rounded[Q_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/tmmb_half_trig.sv
// ============================================================================
// Half-angle cosine and sine
// Wraps an angle in degrees into one turn, halves it into Q30 radians and
// runs a pipelined CORDIC rotation to give its cosine and sine in Q30.
// ============================================================================
`default_nettype none

module tmmb_half_trig #(
    parameter int FRAC_BITS  = 16,
    parameter int TRIG_STEPS = 16
) (
    input  wire logic           aclk,
    input  wire logic           en,
    input  wire tmmb_pkg::word_t angle,
    output tmmb_pkg::q_t        cos_q30,
    output tmmb_pkg::q_t        sin_q30
);

    localparam int W     = tmmb_pkg::WORD_WIDTH;
    localparam int QW    = tmmb_pkg::Q_W;
    localparam int IW    = W - FRAC_BITS;
    localparam int UW    = IW + 9;
    localparam int RW    = tmmb_pkg::RES_W;
    localparam int EW    = ((W > FRAC_BITS + 9) ? W : FRAC_BITS + 9) + 2;
    localparam int AW    = FRAC_BITS + 9;
    localparam int MAGW  = FRAC_BITS + 8;
    localparam int PRW   = MAGW + tmmb_pkg::PI_W;
    localparam int MSPS  = tmmb_pkg::MOD_STEPS_PER_STAGE;
    localparam int CSPS  = tmmb_pkg::CORDIC_STEPS_PER_STAGE;
    localparam int MS    = (IW + MSPS - 1) / MSPS;
    localparam int NSTEP = tmmb_pkg::cordic_steps(TRIG_STEPS);
    localparam int CS    = (NSTEP + CSPS - 1) / CSPS;

    localparam logic [UW-1:0] MOD_UNIT   = UW'(tmmb_pkg::DEG_FULL);
    localparam logic [UW-1:0] MOD_OFFSET = (MOD_UNIT << (IW - 1)) + UW'(tmmb_pkg::DEG_HALF);
    localparam logic signed [EW-1:0] HALF_E = EW'(tmmb_pkg::DEG_HALF) <<< FRAC_BITS;

    logic [UW-1:0]        res_reg  [MS+1];
    logic [FRAC_BITS-1:0] frac_reg [MS+1];
    logic                 gt_reg   [MS+1];
    logic                 lt_reg   [MS+1];
    tmmb_pkg::word_t      ang_reg  [MS+1];

    logic signed [EW-1:0] ang_ext;
    logic [UW-1:0]        res_next;

    assign ang_ext  = EW'(angle);
    assign res_next = UW'($signed(angle[W-1:FRAC_BITS])) + MOD_OFFSET;

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg[0]  <= res_next;
            frac_reg[0] <= angle[FRAC_BITS-1:0];
            gt_reg[0]   <= ang_ext > HALF_E;
            lt_reg[0]   <= ang_ext < -HALF_E;
            ang_reg[0]  <= angle;
        end
    end

    for (genvar s = 1; s <= MS; s++) begin : g_mod
        logic [UW-1:0] step_next;

        always_comb begin
            step_next = res_reg[s-1];
            for (int j = 0; j < MSPS; j++) begin
                if (IW - 1 - (s - 1) * MSPS - j >= 0) begin
                    if (step_next >= (MOD_UNIT << (IW - 1 - (s - 1) * MSPS - j))) begin
                        step_next = step_next - (MOD_UNIT << (IW - 1 - (s - 1) * MSPS - j));
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                res_reg[s]  <= step_next;
                frac_reg[s] <= frac_reg[s-1];
                gt_reg[s]   <= gt_reg[s-1];
                lt_reg[s]   <= lt_reg[s-1];
                ang_reg[s]  <= ang_reg[s-1];
            end
        end
    end

    logic [RW+FRAC_BITS-1:0] turn_mag;
    logic signed [EW-1:0]    turn_ext;
    logic signed [EW-1:0]    wrap_ext;
    logic signed [AW-1:0]    wrap_next;
    logic signed [AW-1:0]    wrap_reg;

    assign turn_mag  = {res_reg[MS][RW-1:0], frac_reg[MS]};
    assign turn_ext  = $signed(EW'(turn_mag));
    assign wrap_next = wrap_ext[AW-1:0];

    always_comb begin
        if (gt_reg[MS]) begin
            wrap_ext = (turn_mag == '0) ? HALF_E : turn_ext - HALF_E;
        end else if (lt_reg[MS]) begin
            wrap_ext = turn_ext - HALF_E;
        end else begin
            wrap_ext = EW'(ang_reg[MS]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            wrap_reg <= wrap_next;
        end
    end

    logic [AW-1:0]   wrap_abs;
    logic [PRW-1:0]  prod_next;
    logic [PRW-1:0]  prod_reg;
    logic            pneg_reg;

    assign wrap_abs  = wrap_reg[AW-1] ? AW'(-wrap_reg) : AW'(wrap_reg);
    assign prod_next = PRW'(wrap_abs[MAGW-1:0]) * PRW'(tmmb_pkg::PI_OVER_360_Q32);

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
            pneg_reg <= wrap_reg[AW-1];
        end
    end

    logic [PRW:0]  zsum;
    tmmb_pkg::q_t  z_next;

    assign zsum   = {1'b0, prod_reg} + ((PRW + 1)'(1) << (FRAC_BITS + 1));
    assign z_next = QW'(zsum >> (FRAC_BITS + 2));

    tmmb_pkg::q_t cx_reg [CS+1];
    tmmb_pkg::q_t cy_reg [CS+1];
    tmmb_pkg::q_t cz_reg [CS+1];
    logic         cn_reg [CS+1];

    always_ff @(posedge aclk) begin
        if (en) begin
            cx_reg[0] <= QW'(tmmb_pkg::GAIN_INV_Q30);
            cy_reg[0] <= '0;
            cz_reg[0] <= z_next;
            cn_reg[0] <= pneg_reg;
        end
    end

    for (genvar c = 1; c <= CS; c++) begin : g_rot
        tmmb_pkg::q_t x_next;
        tmmb_pkg::q_t y_next;
        tmmb_pkg::q_t z_rot_next;

        always_comb begin
            tmmb_pkg::q_t dx;
            tmmb_pkg::q_t dy;
            x_next     = cx_reg[c-1];
            y_next     = cy_reg[c-1];
            z_rot_next = cz_reg[c-1];
            for (int j = 0; j < CSPS; j++) begin
                if ((c - 1) * CSPS + j < NSTEP) begin
                    dx = y_next >>> ((c - 1) * CSPS + j);
                    dy = x_next >>> ((c - 1) * CSPS + j);
                    if (!z_rot_next[QW-1]) begin
                        x_next     = x_next - dx;
                        y_next     = y_next + dy;
                        z_rot_next = z_rot_next
                                     - $signed(QW'(tmmb_pkg::ATAN_Q30[(c - 1) * CSPS + j]));
                    end else begin
                        x_next     = x_next + dx;
                        y_next     = y_next - dy;
                        z_rot_next = z_rot_next
                                     + $signed(QW'(tmmb_pkg::ATAN_Q30[(c - 1) * CSPS + j]));
                    end
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                cx_reg[c] <= x_next;
                cy_reg[c] <= y_next;
                cz_reg[c] <= z_rot_next;
                cn_reg[c] <= cn_reg[c-1];
            end
        end
    end

    tmmb_pkg::q_t cos_reg;
    tmmb_pkg::q_t sin_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= cx_reg[CS];
            sin_reg <= cn_reg[CS] ? -cy_reg[CS] : cy_reg[CS];
        end
    end

    assign cos_q30 = cos_reg;
    assign sin_q30 = sin_reg;

endmodule

`default_nettype wire

### rtl/trs_model_matrix_builder_top.sv
// ============================================================================
// TRS model matrix builder
// Builds the upper 3x4 of translate * rotate * scale from a position, three
// Euler angles in degrees, three scale factors; one item per unstalled cycle.
// ============================================================================
// The input channel (s_valid, s_ready, s_data) takes one transfer per item;
// the result channel (m_valid, m_ready, m_data) gives one transfer per item,
// in order. A transfer may be taken on every clock cycle.
// A result reaches m_valid after the angle unit, the quaternion and scaling
// stages and the output register. The angle unit latency is set by the
// modulo-360 reduction (two bits per stage) and the CORDIC rotation (two
// steps per stage); the quaternion and scaling part takes nine stages,
// each one rank of multipliers or rounding adds; the last saturates.
// When the receiver stalls, the result waits in the output register and a
// second result is caught in a skid register; only then does s_ready fall,
// and the whole pipeline holds its contents until the skid register drains.
// aresetn is synchronous and active low; it empties the pipeline, the output
// register and the skid register. No register setup is needed.
// ============================================================================
`default_nettype none

module trs_model_matrix_builder_top #(
    parameter int FRAC_BITS  = 16,
    parameter int TRIG_STEPS = 16
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire tmmb_pkg::trs_in_t  s_data,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output tmmb_pkg::trs_out_t      m_data
);

    localparam int W   = tmmb_pkg::WORD_WIDTH;
    localparam int QW  = tmmb_pkg::Q_W;
    localparam int LO  = W / 2;
    localparam int LAT = tmmb_pkg::lane_latency(FRAC_BITS, TRIG_STEPS);
    localparam int D   = LAT + 9;
    localparam int FW  = QW + W + 1;
    localparam int MGW = FW - tmmb_pkg::Q_FRAC;

    localparam logic [MGW-1:0] LIM = MGW'(1) << (W - 1);

    typedef struct packed {
        tmmb_pkg::word_t pos_x;
        tmmb_pkg::word_t pos_y;
        tmmb_pkg::word_t pos_z;
        tmmb_pkg::word_t scale_x;
        tmmb_pkg::word_t scale_y;
        tmmb_pkg::word_t scale_z;
    } side_t;

    logic         en;
    logic [D-1:0] vld_reg;
    side_t        side_reg [LAT+8];

    logic out_valid_reg;
    logic skid_valid_reg;
    tmmb_pkg::trs_out_t out_reg;
    tmmb_pkg::trs_out_t skid_reg;

    assign en      = !skid_valid_reg;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[D-2:0], s_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= '{s_data.pos_x, s_data.pos_y, s_data.pos_z,
                             s_data.scale_x, s_data.scale_y, s_data.scale_z};
            for (int k = 1; k < LAT + 8; k++) begin
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    tmmb_pkg::q_t cos_x, sin_x, cos_y, sin_y, cos_z, sin_z;

    tmmb_half_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS)) u_trig_x (
        .aclk(aclk), .en(en), .angle(s_data.angle_x), .cos_q30(cos_x), .sin_q30(sin_x)
    );

    tmmb_half_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS)) u_trig_y (
        .aclk(aclk), .en(en), .angle(s_data.angle_y), .cos_q30(cos_y), .sin_q30(sin_y)
    );

    tmmb_half_trig #(.FRAC_BITS(FRAC_BITS), .TRIG_STEPS(TRIG_STEPS)) u_trig_z (
        .aclk(aclk), .en(en), .angle(s_data.angle_z), .cos_q30(cos_z), .sin_q30(sin_z)
    );

    // Y times X.
    tmmb_pkg::prod_t p_aw_reg, p_ax_reg, p_ay_reg, p_az_reg;
    tmmb_pkg::q_t    q1_cz_reg, q1_sz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_aw_reg  <= cos_y * cos_x;
            p_ax_reg  <= cos_y * sin_x;
            p_ay_reg  <= sin_y * cos_x;
            p_az_reg  <= sin_y * sin_x;
            q1_cz_reg <= cos_z;
            q1_sz_reg <= sin_z;
        end
    end

    tmmb_pkg::q_t aw_reg, ax_reg, ay_reg, az_reg, q2_cz_reg, q2_sz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            aw_reg    <= tmmb_pkg::rnd30(tmmb_pkg::acc_t'(p_aw_reg));
            ax_reg    <= tmmb_pkg::rnd30(tmmb_pkg::acc_t'(p_ax_reg));
            ay_reg    <= tmmb_pkg::rnd30(tmmb_pkg::acc_t'(p_ay_reg));
            az_reg    <= -tmmb_pkg::rnd30(tmmb_pkg::acc_t'(p_az_reg));
            q2_cz_reg <= q1_cz_reg;
            q2_sz_reg <= q1_sz_reg;
        end
    end

    // Then times Z.
    tmmb_pkg::prod_t p_awcz_reg, p_azsz_reg, p_axcz_reg, p_aysz_reg;
    tmmb_pkg::prod_t p_aycz_reg, p_axsz_reg, p_azcz_reg, p_awsz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            p_awcz_reg <= aw_reg * q2_cz_reg;
            p_azsz_reg <= az_reg * q2_sz_reg;
            p_axcz_reg <= ax_reg * q2_cz_reg;
            p_aysz_reg <= ay_reg * q2_sz_reg;
            p_aycz_reg <= ay_reg * q2_cz_reg;
            p_axsz_reg <= ax_reg * q2_sz_reg;
            p_azcz_reg <= az_reg * q2_cz_reg;
            p_awsz_reg <= aw_reg * q2_sz_reg;
        end
    end

    tmmb_pkg::q_t qw_reg, qx_reg, qy_reg, qz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            qw_reg <= tmmb_pkg::rnd30(tmmb_pkg::acc_t'(p_awcz_reg)
                                      - tmmb_pkg::acc_t'(p_azsz_reg));
            qx_reg <= tmmb_pkg::rnd30(tmmb_pkg::acc_t'(p_axcz_reg)
                                      + tmmb_pkg::acc_t'(p_aysz_reg));
            qy_reg <= tmmb_pkg::rnd30(tmmb_pkg::acc_t'(p_aycz_reg)
                                      - tmmb_pkg::acc_t'(p_axsz_reg));
            qz_reg <= tmmb_pkg::rnd30(tmmb_pkg::acc_t'(p_azcz_reg)
                                      + tmmb_pkg::acc_t'(p_awsz_reg));
        end
    end

    // Quaternion to rotation.
    tmmb_pkg::prod_t xx_reg, yy_reg, zz_reg, xy_reg, xz_reg, yz_reg, wx_reg, wy_reg, wz_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            xx_reg <= qx_reg * qx_reg;
            yy_reg <= qy_reg * qy_reg;
            zz_reg <= qz_reg * qz_reg;
            xy_reg <= qx_reg * qy_reg;
            xz_reg <= qx_reg * qz_reg;
            yz_reg <= qy_reg * qz_reg;
            wx_reg <= qw_reg * qx_reg;
            wy_reg <= qw_reg * qy_reg;
            wz_reg <= qw_reg * qz_reg;
        end
    end

    tmmb_pkg::q_t rot_next [9];
    tmmb_pkg::q_t rot_reg  [9];

    always_comb begin
        rot_next[0] = tmmb_pkg::Q_ONE - tmmb_pkg::rnd30(
            (tmmb_pkg::acc_t'(yy_reg) + tmmb_pkg::acc_t'(zz_reg)) <<< 1);
        rot_next[1] = tmmb_pkg::rnd30(
            (tmmb_pkg::acc_t'(xy_reg) - tmmb_pkg::acc_t'(wz_reg)) <<< 1);
        rot_next[2] = tmmb_pkg::rnd30(
            (tmmb_pkg::acc_t'(xz_reg) + tmmb_pkg::acc_t'(wy_reg)) <<< 1);
        rot_next[3] = tmmb_pkg::rnd30(
            (tmmb_pkg::acc_t'(xy_reg) + tmmb_pkg::acc_t'(wz_reg)) <<< 1);
        rot_next[4] = tmmb_pkg::Q_ONE - tmmb_pkg::rnd30(
            (tmmb_pkg::acc_t'(xx_reg) + tmmb_pkg::acc_t'(zz_reg)) <<< 1);
        rot_next[5] = tmmb_pkg::rnd30(
            (tmmb_pkg::acc_t'(yz_reg) - tmmb_pkg::acc_t'(wx_reg)) <<< 1);
        rot_next[6] = tmmb_pkg::rnd30(
            (tmmb_pkg::acc_t'(xz_reg) - tmmb_pkg::acc_t'(wy_reg)) <<< 1);
        rot_next[7] = tmmb_pkg::rnd30(
            (tmmb_pkg::acc_t'(yz_reg) + tmmb_pkg::acc_t'(wx_reg)) <<< 1);
        rot_next[8] = tmmb_pkg::Q_ONE - tmmb_pkg::rnd30(
            (tmmb_pkg::acc_t'(xx_reg) + tmmb_pkg::acc_t'(yy_reg)) <<< 1);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rot_reg <= rot_next;
        end
    end

    // Column scaling: magnitude product in two halves of the scale.
    tmmb_pkg::word_t   scale_col [3];
    logic [QW+LO-1:0]  ph_next [9];
    logic [QW+LO-1:0]  pl_next [9];
    logic              sneg_next [9];
    logic [QW+LO-1:0]  ph_reg [9];
    logic [QW+LO-1:0]  pl_reg [9];
    logic              sneg_reg [9];

    assign scale_col[0] = side_reg[LAT+5].scale_x;
    assign scale_col[1] = side_reg[LAT+5].scale_y;
    assign scale_col[2] = side_reg[LAT+5].scale_z;

    always_comb begin
        logic [QW-1:0] mr;
        logic [W-1:0]  ms;
        for (int k = 0; k < 9; k++) begin
            mr = rot_reg[k][QW-1] ? QW'(-rot_reg[k]) : QW'(rot_reg[k]);
            ms = scale_col[k % 3][W-1] ? W'(-scale_col[k % 3]) : W'(scale_col[k % 3]);
            ph_next[k]   = (QW + LO)'(mr) * (QW + LO)'(ms[W-1:LO]);
            pl_next[k]   = (QW + LO)'(mr) * (QW + LO)'(ms[LO-1:0]);
            sneg_next[k] = rot_reg[k][QW-1] ^ scale_col[k % 3][W-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ph_reg   <= ph_next;
            pl_reg   <= pl_next;
            sneg_reg <= sneg_next;
        end
    end

    logic [MGW-1:0] mag_next [9];
    logic [MGW-1:0] mag_reg  [9];
    logic           mneg_reg [9];

    always_comb begin
        logic [FW-1:0] full;
        for (int k = 0; k < 9; k++) begin
            full = (FW'(ph_reg[k]) << LO) + FW'(pl_reg[k])
                   + (FW'(1) << (tmmb_pkg::Q_FRAC - 1));
            mag_next[k] = full[FW-1:tmmb_pkg::Q_FRAC];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag_reg  <= mag_next;
            mneg_reg <= sneg_reg;
        end
    end

    tmmb_pkg::word_t    ent_next [9];
    tmmb_pkg::trs_out_t res_next;
    tmmb_pkg::trs_out_t res_reg;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            if (mneg_reg[k]) begin
                ent_next[k] = (mag_reg[k] > LIM) ? W'(LIM) : W'(-mag_reg[k]);
            end else begin
                ent_next[k] = (mag_reg[k] > LIM - MGW'(1)) ? W'(LIM - MGW'(1))
                                                           : W'(mag_reg[k]);
            end
        end
        res_next.m00 = ent_next[0];
        res_next.m01 = ent_next[1];
        res_next.m02 = ent_next[2];
        res_next.m03 = side_reg[LAT+7].pos_x;
        res_next.m10 = ent_next[3];
        res_next.m11 = ent_next[4];
        res_next.m12 = ent_next[5];
        res_next.m13 = side_reg[LAT+7].pos_y;
        res_next.m20 = ent_next[6];
        res_next.m21 = ent_next[7];
        res_next.m22 = ent_next[8];
        res_next.m23 = side_reg[LAT+7].pos_z;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
        end
    end

    // Output register and skid register.
    logic take;
    logic arrive;

    assign take   = out_valid_reg && m_ready;
    assign arrive = en && vld_reg[D-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= arrive;
            end
        end else if (arrive) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || take) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (arrive) begin
                out_reg <= res_reg;
            end
        end else if (arrive) begin
            skid_reg <= res_reg;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    a_skid_needs_output: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a result while the output register is empty.");

    a_skid_fills_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_ready))
        else $error("Skid register filled without a stalled output transfer.");

    a_pipe_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> vld_reg == $past(vld_reg))
        else $error("Pipeline valid bits moved while the pipeline was held.");

endmodule

`default_nettype wire

### tb/sv/tb_trs_model_matrix_builder_top.sv
// ============================================================================
// TRS model matrix builder testbench
// Sends position, angle and scale transfers through the builder with random
// gaps and receiver stalls. Each expected matrix is computed bit for bit by a
// behavioural model of the angle wrap, CORDIC, quaternion and scaling
// arithmetic, and every result transfer is checked field by field in order.
// ============================================================================
`default_nettype none

module tb_trs_model_matrix_builder_top;

    localparam longint HALF_TURN   = 64'sd180 <<< 16;
    localparam longint FULL_TURN   = 64'sd360 <<< 16;
    localparam longint ONE_Q30     = 64'sd1 <<< 30;
    localparam longint HALF_Q30    = 64'sd1 <<< 29;
    localparam int     TRIG_ROUNDS = 16;
    localparam int     RANDOM_ITEMS = 450;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    tmmb_pkg::trs_in_t  s_data;
    logic               m_valid;
    logic               m_ready;
    tmmb_pkg::trs_out_t m_data;

    tmmb_pkg::trs_in_t  pending_items[$];
    tmmb_pkg::trs_out_t expected_matrices[$];
    int                 mismatches;
    int                 cycle_count;
    logic               in_taken;
    logic               stimulus_loaded;

    trs_model_matrix_builder_top u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    function automatic longint round_q30(input longint p);
        return (p + HALF_Q30) >>> 30;
    endfunction

    function automatic longint wrap_degrees(input longint a);
        longint turns;
        if (a > HALF_TURN) begin
            turns = (a - HALF_TURN + FULL_TURN - 1) / FULL_TURN;
            a     = a - turns * FULL_TURN;
        end else if (a < -HALF_TURN) begin
            turns = (-HALF_TURN - a + FULL_TURN - 1) / FULL_TURN;
            a     = a + turns * FULL_TURN;
        end
        return a;
    endfunction

    function automatic void half_angle_trig(input longint deg, output longint c,
                                            output longint s);
        logic            neg;
        longint unsigned mag;
        longint unsigned prod;
        longint          z;
        longint          x;
        longint          y;
        longint          dx;
        longint          dy;
        neg  = deg < 0;
        mag  = neg ? -deg : deg;
        prod = mag * longint'(tmmb_pkg::PI_OVER_360_Q32) + (64'd1 << 17);
        z    = longint'(prod >> 18);
        x    = longint'(tmmb_pkg::GAIN_INV_Q30);
        y    = 0;
        for (int i = 0; i < TRIG_ROUNDS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x = x - dx;
                y = y + dy;
                z = z - longint'(tmmb_pkg::ATAN_Q30[i]);
            end else begin
                x = x + dx;
                y = y - dy;
                z = z + longint'(tmmb_pkg::ATAN_Q30[i]);
            end
        end
        c = x;
        s = neg ? -y : y;
    endfunction

    function automatic tmmb_pkg::word_t scaled_entry(input longint r, input longint sc);
        logic            neg;
        longint unsigned mr;
        longint unsigned ms;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned mag;
        neg = (r < 0) != (sc < 0);
        mr  = r < 0 ? -r : r;
        ms  = sc < 0 ? -sc : sc;
        hi  = mr * (ms >> 24);
        lo  = mr * (ms & 64'hFF_FFFF);
        mag = (hi >> 6) + ((((hi & 64'd63) << 24) + lo + (64'd1 << 29)) >> 30);
        if (neg) begin
            if (mag > (64'd1 << 31)) begin
                mag = 64'd1 << 31;
            end
            return tmmb_pkg::word_t'(64'd0 - mag);
        end
        if (mag > (64'd1 << 31) - 1) begin
            mag = (64'd1 << 31) - 1;
        end
        return tmmb_pkg::word_t'(mag);
    endfunction

    function automatic tmmb_pkg::trs_out_t build_matrix(input tmmb_pkg::trs_in_t item);
        longint             cx, sx, cy, sy, cz, sz;
        longint             aw, ax, ay, az, qw, qx, qy, qz;
        longint             rot [3][3];
        longint             scl [3];
        tmmb_pkg::trs_out_t res;
        half_angle_trig(wrap_degrees(longint'(item.angle_x)), cx, sx);
        half_angle_trig(wrap_degrees(longint'(item.angle_y)), cy, sy);
        half_angle_trig(wrap_degrees(longint'(item.angle_z)), cz, sz);
        aw = round_q30(cy * cx);
        ax = round_q30(cy * sx);
        ay = round_q30(sy * cx);
        az = -round_q30(sy * sx);
        qw = round_q30(aw * cz - az * sz);
        qx = round_q30(ax * cz + ay * sz);
        qy = round_q30(ay * cz - ax * sz);
        qz = round_q30(az * cz + aw * sz);
        rot[0][0] = ONE_Q30 - round_q30(2 * (qy * qy + qz * qz));
        rot[1][0] = round_q30(2 * (qx * qy + qw * qz));
        rot[2][0] = round_q30(2 * (qx * qz - qw * qy));
        rot[0][1] = round_q30(2 * (qx * qy - qw * qz));
        rot[1][1] = ONE_Q30 - round_q30(2 * (qx * qx + qz * qz));
        rot[2][1] = round_q30(2 * (qy * qz + qw * qx));
        rot[0][2] = round_q30(2 * (qx * qz + qw * qy));
        rot[1][2] = round_q30(2 * (qy * qz - qw * qx));
        rot[2][2] = ONE_Q30 - round_q30(2 * (qx * qx + qy * qy));
        scl[0] = longint'(item.scale_x);
        scl[1] = longint'(item.scale_y);
        scl[2] = longint'(item.scale_z);
        res.m00 = scaled_entry(rot[0][0], scl[0]);
        res.m01 = scaled_entry(rot[0][1], scl[1]);
        res.m02 = scaled_entry(rot[0][2], scl[2]);
        res.m03 = item.pos_x;
        res.m10 = scaled_entry(rot[1][0], scl[0]);
        res.m11 = scaled_entry(rot[1][1], scl[1]);
        res.m12 = scaled_entry(rot[1][2], scl[2]);
        res.m13 = item.pos_y;
        res.m20 = scaled_entry(rot[2][0], scl[0]);
        res.m21 = scaled_entry(rot[2][1], scl[1]);
        res.m22 = scaled_entry(rot[2][2], scl[2]);
        res.m23 = item.pos_z;
        return res;
    endfunction

    function automatic tmmb_pkg::word_t degrees_q16(input int deg);
        return tmmb_pkg::word_t'(deg <<< 16);
    endfunction

    function automatic tmmb_pkg::word_t random_angle();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
            return tmmb_pkg::word_t'(int'($urandom_range(0, 1440 << 16)) - (720 << 16));
        end else if (pick < 8) begin
            return degrees_q16(int'($urandom_range(0, 8)) * 90 - 360)
                   + tmmb_pkg::word_t'(int'($urandom_range(0, 2)) - 1);
        end
        return tmmb_pkg::word_t'($urandom);
    endfunction

    function automatic tmmb_pkg::word_t random_scale();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 7) begin
            return tmmb_pkg::word_t'(int'($urandom_range(0, 16 << 16)) - (8 << 16));
        end else if (pick < 8) begin
            return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
        end
        return tmmb_pkg::word_t'($urandom);
    endfunction

    function automatic tmmb_pkg::trs_in_t make_item(
        input tmmb_pkg::word_t ax, input tmmb_pkg::word_t ay, input tmmb_pkg::word_t az,
        input tmmb_pkg::word_t sx, input tmmb_pkg::word_t sy, input tmmb_pkg::word_t sz);
        tmmb_pkg::trs_in_t item;
        item.pos_x   = tmmb_pkg::word_t'($urandom);
        item.pos_y   = tmmb_pkg::word_t'($urandom);
        item.pos_z   = tmmb_pkg::word_t'($urandom);
        item.angle_x = ax;
        item.angle_y = ay;
        item.angle_z = az;
        item.scale_x = sx;
        item.scale_y = sy;
        item.scale_z = sz;
        return item;
    endfunction

    function automatic logic idle_now();
        if (cycle_count >= 250 && cycle_count < 450) begin
            return 1'b0;
        end
        return $urandom_range(0, 99) < 22;
    endfunction

    initial begin
        tmmb_pkg::word_t   one;
        tmmb_pkg::word_t   top;
        tmmb_pkg::word_t   bot;
        tmmb_pkg::trs_in_t item;
        one = 32'sh0001_0000;
        top = 32'sh7FFF_FFFF;
        bot = 32'sh8000_0000;
        stimulus_loaded = 1'b0;
        item = make_item(0, 0, 0, one, one, one);
        item.pos_x = 0;
        item.pos_y = 0;
        item.pos_z = 0;
        pending_items.push_back(item);
        item = make_item(0, 0, 0, one, one, one);
        item.pos_x = top;
        item.pos_y = bot;
        item.pos_z = 32'shFFFF_FFFF;
        pending_items.push_back(item);
        pending_items.push_back(make_item(degrees_q16(180), degrees_q16(-180),
                                          degrees_q16(180), one, one, one));
        pending_items.push_back(make_item(degrees_q16(180) + 1, degrees_q16(-180) - 1,
                                          degrees_q16(180) - 1, one, one, one));
        pending_items.push_back(make_item(top, bot, top, one, one, one));
        pending_items.push_back(make_item(bot, top, bot, one, one, one));
        pending_items.push_back(make_item(degrees_q16(90), degrees_q16(-90),
                                          degrees_q16(45), one, one, one));
        pending_items.push_back(make_item(degrees_q16(360), degrees_q16(720),
                                          degrees_q16(-1080), one, one, one));
        pending_items.push_back(make_item(0, 0, 0, top, top, top));
        pending_items.push_back(make_item(0, 0, 0, bot, bot, bot));
        pending_items.push_back(make_item(degrees_q16(180), 0, 0, top, bot, top));
        pending_items.push_back(make_item(degrees_q16(30), degrees_q16(60),
                                          degrees_q16(-45), bot, top, bot));
        pending_items.push_back(make_item(1, -1, 0, 0, 0, 0));
        pending_items.push_back(make_item(degrees_q16(-90), degrees_q16(270),
                                          degrees_q16(135), -one, one, -one));
        pending_items.push_back(make_item(tmmb_pkg::word_t'(32'h5555_5555),
                                          tmmb_pkg::word_t'(32'hAAAA_AAAA),
                                          tmmb_pkg::word_t'(32'h0F0F_0F0F),
                                          tmmb_pkg::word_t'(32'h5555_5555),
                                          tmmb_pkg::word_t'(32'hAAAA_AAAA),
                                          tmmb_pkg::word_t'(32'hF0F0_F0F0)));
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pending_items.push_back(make_item(random_angle(), random_angle(), random_angle(),
                                              random_scale(), random_scale(),
                                              random_scale()));
        end
        stimulus_loaded = 1'b1;
    end

    initial begin
        aresetn     = 1'b0;
        s_valid     = 1'b0;
        s_data      = '0;
        m_ready     = 1'b0;
        mismatches  = 0;
        cycle_count = 0;
        in_taken    = 1'b0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        in_taken    <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            expected_matrices.push_back(build_matrix(s_data));
        end
        if (aresetn && m_valid && m_ready) begin
            if (expected_matrices.size() == 0) begin
                $display("%0t: result transfer with nothing expected, actual %h",
                         $time, m_data);
                mismatches = mismatches + 1;
            end else begin
                tmmb_pkg::trs_out_t want;
                want = expected_matrices.pop_front();
                for (int k = 0; k < 12; k++) begin
                    if (m_data[(11 - k) * 32 +: 32] !== want[(11 - k) * 32 +: 32]) begin
                        $display("%0t: m%0d%0d expected %h actual %h", $time, k / 4, k % 4,
                                 want[(11 - k) * 32 +: 32], m_data[(11 - k) * 32 +: 32]);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= !idle_now();
            if (!s_valid || in_taken) begin
                if (pending_items.size() != 0 && stimulus_loaded && !idle_now()) begin
                    s_data  <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    initial begin
        wait (stimulus_loaded && aresetn);
        @(posedge aclk);
        while (pending_items.size() != 0 || s_valid || expected_matrices.size() != 0) begin
            @(posedge aclk);
        end
        repeat (40) @(posedge aclk);
        if (mismatches == 0 && !m_valid) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
